FILE: sv/rte_pkg.sv
// Shared types and constants for the regime transition estimator.
package rte_pkg;

  localparam int unsigned DVD_W = 52;
  localparam int unsigned DVS_W = 37;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGIME_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORGET_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIOR_DIAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIOR_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd5;

  localparam logic [12:0] TALLY_MAX = 13'd8191;

  typedef struct packed {
    logic        learn_enable;
    logic [3:0]  regimes;        // active regime count, already clipped
    logic [15:0] forget_factor;
    logic [15:0] prior_diagonal;
    logic [15:0] prior_off_diagonal;
    logic [15:0] update_interval;
  } cfg_t;

  // Classified particle word passed from front to back.
  typedef struct packed {
    logic [2:0] from_regime;
    logic [2:0] to_regime;
    logic       in_range;
    logic       tick_end;
  } word_t;

endpackage

FILE: sv/rte_front.sv
// Front end: accepts particle words, classifies them and queues them.
module rte_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  rte_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         from_regime,
  input  logic [2:0]         to_regime,
  input  logic               tick_end,
  output logic               q_valid,
  output rte_pkg::word_t     q_word,
  input  logic               q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rte_pkg::word_t      fifo [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;
  logic                accept;
  logic                push;
  rte_pkg::word_t      word_in;

  assign item_stall = (count == CW'(DEPTH));
  assign accept = item_valid && !item_stall;
  // learning disabled: word is taken and dropped
  assign push = accept && cfg.learn_enable;
  assign q_valid = (count != '0);
  assign q_word = fifo[rd_ptr];

  always_comb begin
    word_in.from_regime = from_regime;
    word_in.to_regime = to_regime;
    word_in.in_range = ({1'b0, from_regime} < cfg.regimes) &&
                       ({1'b0, to_regime} < cfg.regimes);
    word_in.tick_end = tick_end;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(q_pop && q_valid);
    end
  end

endmodule

FILE: sv/rte_div.sv
// Restoring divider, one quotient bit per cycle.
module rte_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rte_pkg::DVD_W-1:0]  dividend,
  input  logic [rte_pkg::DVS_W-1:0]  divisor,
  output logic [rte_pkg::DVD_W-1:0]  quotient,
  output logic                       done
);

  localparam int unsigned RW = rte_pkg::DVS_W + 1;
  localparam int unsigned NW = $clog2(rte_pkg::DVD_W + 1);

  logic [rte_pkg::DVD_W-1:0] dvd;
  logic [rte_pkg::DVS_W-1:0] dvs;
  logic [RW-1:0]             rem;
  logic [NW-1:0]             steps;
  logic                      busy;
  logic [RW-1:0]             trial;
  logic                      fits;

  assign trial = {rem[RW-2:0], dvd[rte_pkg::DVD_W-1]};
  assign fits = (trial >= {1'b0, dvs});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      dvd <= {dvd[rte_pkg::DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == NW'(rte_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/rte_back.sv
// Back end: tallies, tick close (decay and increment) and matrix emission.
module rte_back #(
  parameter int unsigned MAX_REGIMES = 8,
  parameter int unsigned MAX_PARTICLES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  rte_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  rte_pkg::word_t     q_word,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         row_index,
  output logic [2:0]         col_index,
  output logic [15:0]        probability,
  output logic               matrix_last
);

  localparam int unsigned DEPTH = MAX_REGIMES * MAX_REGIMES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_TINC  = 13'b0000000000010,
    S_CRD   = 13'b0000000000100,
    S_CMUL  = 13'b0000000001000,
    S_CDIV  = 13'b0000000010000,
    S_CWR   = 13'b0000000100000,
    S_CEND  = 13'b0000001000000,
    S_ESRD  = 13'b0000010000000,
    S_ESACC = 13'b0000100000000,
    S_EDRD  = 13'b0001000000000,
    S_EDST  = 13'b0010000000000,
    S_EDIV  = 13'b0100000000000,
    S_EOUT  = 13'b1000000000000
  } state_t;

  state_t                     state;
  logic [31:0]                pc_mem [DEPTH];
  logic [12:0]                tt_mem [DEPTH];
  logic [DEPTH-1:0]           pc_vld;
  logic [DEPTH-1:0]           tt_vld;
  logic [31:0]                pc_rd;
  logic                       pc_rdv;
  logic [12:0]                tt_rd;
  logic                       tt_rdv;
  logic [AW-1:0]              tt_raddr;
  logic                       tt_we;
  logic [12:0]                tt_wdata;
  logic                       pc_we;
  logic [31:0]                pc_wdata;

  logic [PW-1:0]              part_cnt;
  logic [15:0]                ticks;
  logic [3:0]                 ri;
  logic [3:0]                 rj;
  logic [AW-1:0]              k;
  logic [AW-1:0]              word_k;
  logic [7:0]                 k_wide;
  logic [7:0]                 word_k_wide;
  logic                       tally_en;
  logic                       word_last;
  logic [AW-1:0]              word_idx;
  logic [47:0]                prod;
  logic [35:0]                row_sum;
  logic [15:0]                prob;

  logic                       div_start;
  logic [rte_pkg::DVD_W-1:0]  div_dvd;
  logic [rte_pkg::DVS_W-1:0]  div_dvs;
  logic [rte_pkg::DVD_W-1:0]  div_q;
  logic                       div_done;

  logic [31:0]                cnt_val;
  logic [12:0]                tally_val;
  logic [15:0]                prior;
  logic [32:0]                entry_v;
  logic [48:0]                decay_sum;
  logic [33:0]                new_count;
  logic [15:0]                ticks_next;
  logic                       j_last;
  logic                       i_last;
  logic                       out_free;

  assign k_wide = 8'(ri) * 8'(MAX_REGIMES) + 8'(rj);
  assign k = k_wide[AW-1:0];
  assign word_k_wide = 8'(q_word.from_regime) * 8'(MAX_REGIMES) + 8'(q_word.to_regime);
  assign word_k = word_k_wide[AW-1:0];
  assign tt_raddr = (state == S_IDLE) ? word_k : k;

  assign cnt_val = pc_rdv ? pc_rd : 32'd0;
  assign tally_val = tt_rdv ? tt_rd : 13'd0;
  assign prior = (ri == rj) ? cfg.prior_diagonal : cfg.prior_off_diagonal;
  assign entry_v = 33'(cnt_val) + 33'({prior, 8'd0});
  assign decay_sum = 49'(prod) + 49'h8000;
  assign new_count = 34'(decay_sum[48:16]) + ((part_cnt != '0) ? div_q[33:0] : 34'd0);
  assign ticks_next = (ticks == 16'hFFFF) ? ticks : ticks + 1'b1;
  assign j_last = (rj + 1'b1 >= cfg.regimes);
  assign i_last = (ri + 1'b1 >= cfg.regimes);
  assign out_free = !result_valid || !result_stall;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign tt_we = (state == S_TINC) && tally_en && (tally_val < rte_pkg::TALLY_MAX);
  assign tt_wdata = tally_val + 1'b1;
  assign pc_we = (state == S_CWR);
  assign pc_wdata = new_count[33:32] != 2'd0 ? 32'hFFFF_FFFF : new_count[31:0];

  always_comb begin
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    if (state == S_CMUL) begin
      div_start = 1'b1;
      div_dvd = rte_pkg::DVD_W'({tally_val, 16'd0}) + rte_pkg::DVD_W'(part_cnt >> 1);
      div_dvs = rte_pkg::DVS_W'(part_cnt);
    end else if (state == S_EDST && row_sum != '0) begin
      div_start = 1'b1;
      div_dvd = (rte_pkg::DVD_W'(entry_v) << 16) + rte_pkg::DVD_W'(row_sum >> 1);
      div_dvs = rte_pkg::DVS_W'(row_sum);
    end
  end

  rte_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // pair count memory
  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[k] <= pc_wdata;
    end
    pc_rd <= pc_mem[k];
    pc_rdv <= pc_vld[k];
  end

  // tick tally memory
  always_ff @(posedge clk) begin
    if (tt_we) begin
      tt_mem[word_idx] <= tt_wdata;
    end
    tt_rd <= tt_mem[tt_raddr];
    tt_rdv <= tt_vld[tt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      word_idx <= word_k;
      word_last <= q_word.tick_end;
    end
    if (state == S_CMUL) begin
      prod <= 48'(cnt_val) * 48'(cfg.forget_factor);
    end
    if (state == S_EDST) begin
      prob <= 16'd0;
    end else if (state == S_EDIV && div_done) begin
      prob <= (div_q > rte_pkg::DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
    end
    if (state == S_EOUT && out_free) begin
      row_index <= ri[2:0];
      col_index <= rj[2:0];
      probability <= prob;
      matrix_last <= i_last && j_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc_vld <= '0;
      tt_vld <= '0;
      part_cnt <= '0;
      ticks <= '0;
      ri <= '0;
      rj <= '0;
      tally_en <= 1'b0;
      row_sum <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_EOUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (tt_we) begin
        tt_vld[word_idx] <= 1'b1;
      end
      if (pc_we) begin
        pc_vld[k] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (part_cnt < PW'(MAX_PARTICLES)) begin
              part_cnt <= part_cnt + 1'b1;
              tally_en <= q_word.in_range;
            end else begin
              tally_en <= 1'b0;
            end
            state <= S_TINC;
          end
        end
        S_TINC: begin
          ri <= '0;
          rj <= '0;
          if (!word_last) begin
            state <= S_IDLE;
          end else if (cfg.regimes == 4'd0) begin
            state <= S_CEND;
          end else begin
            state <= S_CRD;
          end
        end
        S_CRD: state <= S_CMUL;
        S_CMUL: state <= S_CDIV;
        S_CDIV: begin
          if (div_done) begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          if (!j_last) begin
            rj <= rj + 1'b1;
            state <= S_CRD;
          end else if (!i_last) begin
            ri <= ri + 1'b1;
            rj <= '0;
            state <= S_CRD;
          end else begin
            state <= S_CEND;
          end
        end
        S_CEND: begin
          tt_vld <= '0;
          part_cnt <= '0;
          ri <= '0;
          rj <= '0;
          row_sum <= '0;
          if (ticks_next >= cfg.update_interval) begin
            ticks <= '0;
            state <= (cfg.regimes == 4'd0) ? S_IDLE : S_ESRD;
          end else begin
            ticks <= ticks_next;
            state <= S_IDLE;
          end
        end
        S_ESRD: state <= S_ESACC;
        S_ESACC: begin
          row_sum <= row_sum + 36'(entry_v);
          if (!j_last) begin
            rj <= rj + 1'b1;
            state <= S_ESRD;
          end else begin
            rj <= '0;
            state <= S_EDRD;
          end
        end
        S_EDRD: state <= S_EDST;
        S_EDST: state <= (row_sum != '0) ? S_EDIV : S_EOUT;
        S_EDIV: begin
          if (div_done) begin
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            if (!j_last) begin
              rj <= rj + 1'b1;
              state <= S_EDRD;
            end else if (!i_last) begin
              ri <= ri + 1'b1;
              rj <= '0;
              row_sum <= '0;
              state <= S_ESRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_part_bound: assert property (@(posedge clk) disable iff (rst)
    part_cnt <= PW'(MAX_PARTICLES))
    else $error("particle count beyond limit");
  a_tally_no_emit: assert property (@(posedge clk) disable iff (rst)
    tt_we |-> (state == S_TINC))
    else $error("tally write outside increment step");
  a_close_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CEND) |=> (state == S_IDLE || state == S_ESRD))
    else $error("bad exit from tick close");
  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    (!result_valid && !$past(rst)) ##1 result_valid |-> $past(state) == S_EOUT)
    else $error("result raised outside emission");
`endif

endmodule

FILE: sv/regime_transition_estimator_top.sv
// Top level of the regime transition estimator: config registers, front and back.
//
// Particle channel: item_valid/item_stall carry from_regime, to_regime and
// tick_end. A word is taken when item_valid is high and item_stall low.
// Words go into a four-entry queue; the back end drains each word as a tally
// read, then a tally write, and pops the next word only after the write.
// With learn_enable low words are taken and dropped.
// A word with tick_end closes the tick: every active pair count is decayed
// (32x16 multiply) and bumped by tally/particles through a bit-serial
// divider, one entry after another, up to 64 entries. The queue keeps
// taking words until full during this time.
// Every update_interval ticks the matrix is emitted row by row on
// result_valid/result_stall; each entry with a nonzero row sum needs one
// 52-step division, and each row first reads every column for its sum.
// A stalled result holds in the output register and the emission waits.
// Reset (rst, synchronous) restores default config, clears counts,
// tallies and counters via valid bits; no clearing pass.
// Config: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while the block is idle.
module regime_transition_estimator_top #(
  parameter int unsigned MAX_REGIMES = 8,
  parameter int unsigned MAX_PARTICLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  from_regime,
  input  logic [2:0]  to_regime,
  input  logic        tick_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  row_index,
  output logic [2:0]  col_index,
  output logic [15:0] probability,
  output logic        matrix_last
);

  logic           learn_enable;
  logic [3:0]     regime_count;
  logic [15:0]    forget_factor;
  logic [15:0]    prior_diagonal;
  logic [15:0]    prior_off_diagonal;
  logic [15:0]    update_interval;
  rte_pkg::cfg_t  cfg;
  logic           q_valid;
  rte_pkg::word_t q_word;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // regime count above the build limit acts as the limit
  always_comb begin
    cfg.learn_enable = learn_enable;
    cfg.regimes = (regime_count > 4'(MAX_REGIMES)) ? 4'(MAX_REGIMES) : regime_count;
    cfg.forget_factor = forget_factor;
    cfg.prior_diagonal = prior_diagonal;
    cfg.prior_off_diagonal = prior_off_diagonal;
    cfg.update_interval = update_interval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_enable <= 1'b0;
      regime_count <= 4'd4;
      forget_factor <= 16'd65208;
      prior_diagonal <= 16'd12800;
      prior_off_diagonal <= 16'd256;
      update_interval <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        rte_pkg::REG_LEARN_ENABLE: learn_enable <= cfg_data[0];
        rte_pkg::REG_REGIME_COUNT: regime_count <= cfg_data[3:0];
        rte_pkg::REG_FORGET_FACTOR: forget_factor <= cfg_data;
        rte_pkg::REG_PRIOR_DIAG: prior_diagonal <= cfg_data;
        rte_pkg::REG_PRIOR_OFF: prior_off_diagonal <= cfg_data;
        rte_pkg::REG_UPDATE_INTERVAL: update_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  rte_front #(
    .DEPTH (4)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .from_regime (from_regime),
    .to_regime   (to_regime),
    .tick_end    (tick_end),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop)
  );

  rte_back #(
    .MAX_REGIMES   (MAX_REGIMES),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_index    (row_index),
    .col_index    (col_index),
    .probability  (probability),
    .matrix_last  (matrix_last)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the regime transition estimator top level.
module tb;

  localparam int unsigned DRAIN_CYCLES = 20000;  // up to five queued tick closes, plus margin
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 8000;    // long receiver hold-off
  localparam int unsigned PART_CAP = 4096;

  typedef struct {
    bit [2:0]  row;
    bit [2:0]  col;
    bit [15:0] prob;
    bit        last;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [2:0]  from_regime = '0;
  logic [2:0]  to_regime = '0;
  logic        tick_end = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic [15:0] probability;
  logic        matrix_last;

  regime_transition_estimator_top DUT (.*);

  always #4 clk = ~clk;

  // Shadow copy of config and learned state.
  bit        m_learn;
  bit [3:0]  m_regimes;
  bit [15:0] m_forget;
  bit [15:0] m_prior_diag;
  bit [15:0] m_prior_off;
  bit [15:0] m_interval;
  bit [31:0] m_counts[64];
  bit [12:0] pair_tally[64];
  bit [12:0] tick_particles;
  bit [15:0] ticks_since_matrix;

  entry_t matrix_q[$];
  int     err_count = 0;
  bit     quiet = 1'b0;      // no idling on either side
  int     hold_seq = 0;      // bumped to request a long receiver hold-off
  int     idle_cycles = 0;

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Push one emitted transition matrix, row by row.
  task automatic predict_matrix(int unsigned r);
    longint unsigned v[8];
    longint unsigned total;
    longint unsigned p;
    bit [15:0] prior;
    entry_t e;
    for (int i = 0; i < r; i++) begin
      total = 0;
      for (int j = 0; j < r; j++) begin
        prior = (i == j) ? m_prior_diag : m_prior_off;
        v[j] = longint'(m_counts[i*8+j]) + (longint'(prior) << 8);
        total += v[j];
      end
      for (int j = 0; j < r; j++) begin
        p = 0;
        if (total != 0) begin
          p = ((v[j] << 16) + (total >> 1)) / total;
          if (p > 64'hFFFF) p = 64'hFFFF;
        end
        e.row = 3'(i);
        e.col = 3'(j);
        e.prob = p[15:0];
        e.last = (i == r - 1) && (j == r - 1);
        matrix_q.push_back(e);
      end
    end
  endtask

  // Effect of one accepted particle word.
  task automatic predict_word(bit [2:0] f, bit [2:0] t, bit last);
    int unsigned r;
    int unsigned k;
    int unsigned n;
    longint unsigned c;
    r = (m_regimes > 8) ? 8 : 32'(m_regimes);
    if (!m_learn) return;
    if (tick_particles < PART_CAP) begin
      tick_particles++;
      if (f < r && t < r) begin
        k = f * 8 + t;
        if (pair_tally[k] < rte_pkg::TALLY_MAX) pair_tally[k]++;
      end
    end
    if (!last) return;
    // Tick close: decay active counts, add normalized tallies.
    n = 32'(tick_particles);
    for (int i = 0; i < r; i++)
      for (int j = 0; j < r; j++) begin
        k = i * 8 + j;
        c = (longint'(m_counts[k]) * m_forget + 32768) >> 16;
        if (n != 0) c += ((longint'(pair_tally[k]) << 16) + (n >> 1)) / n;
        m_counts[k] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
      end
    foreach (pair_tally[i]) pair_tally[i] = '0;
    tick_particles = '0;
    if (ticks_since_matrix < 16'hFFFF) ticks_since_matrix++;
    if (ticks_since_matrix >= m_interval) begin
      ticks_since_matrix = '0;
      predict_matrix(r);
    end
  endtask

  // Send one particle word; returns at the edge where it is taken.
  task automatic send_word(bit [2:0] f, bit [2:0] t, bit last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_valid <= 1'b1;
    from_regime <= f;
    to_regime <= t;
    tick_end <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_word(f, t, last);
  endtask

  // Let all expected entries arrive, then wait out any silent tick close.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [rte_pkg::CFG_IDX_W-1:0] idx, bit [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rte_pkg::REG_LEARN_ENABLE:    m_learn = data[0];
      rte_pkg::REG_REGIME_COUNT:    m_regimes = data[3:0];
      rte_pkg::REG_FORGET_FACTOR:   m_forget = data;
      rte_pkg::REG_PRIOR_DIAG:      m_prior_diag = data;
      rte_pkg::REG_PRIOR_OFF:       m_prior_off = data;
      rte_pkg::REG_UPDATE_INTERVAL: m_interval = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_all(bit le, bit [3:0] rc, bit [15:0] ff, bit [15:0] pd,
                         bit [15:0] po, bit [15:0] ui);
    cfg_write(rte_pkg::REG_LEARN_ENABLE, 16'(le));
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'(rc));
    cfg_write(rte_pkg::REG_FORGET_FACTOR, ff);
    cfg_write(rte_pkg::REG_PRIOR_DIAG, pd);
    cfg_write(rte_pkg::REG_PRIOR_OFF, po);
    cfg_write(rte_pkg::REG_UPDATE_INTERVAL, ui);
  endtask

  // One tick of random in-range particles.
  task automatic send_tick(int n, int unsigned hi);
    for (int i = 0; i < n; i++)
      send_word(3'($urandom_range(0, hi)), 3'($urandom_range(0, hi)), i == n - 1);
  endtask

  // Receiver: random stall bursts, plus the long hold-off on request.
  int hold_seen = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      stall_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result checker against the oldest expected entry.
  always @(posedge clk) begin
    entry_t e;
    if (!rst && result_valid && !result_stall) begin
      if (matrix_q.size() == 0) begin
        report("unexpected entry row", 32'(row_index), 0);
      end else begin
        e = matrix_q.pop_front();
        if (row_index !== e.row) report("row_index", 32'(row_index), 32'(e.row));
        if (col_index !== e.col) report("col_index", 32'(col_index), 32'(e.col));
        if (probability !== e.prob)
          report("probability", 32'(probability), 32'(e.prob));
        if (matrix_last !== e.last)
          report("matrix_last", 32'(matrix_last), 32'(e.last));
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Learning disabled at reset: words are dropped.
  task automatic test_reset_defaults();
    send_word(3'd1, 3'd2, 1'b0);
    send_word(3'd7, 3'd7, 1'b1);
    wait_idle();
  endtask

  // Field extremes, out-of-range pairs, one matrix per tick.
  task automatic test_basic_tick();
    cfg_all(1'b1, 4'd4, 16'd65208, 16'd12800, 16'd256, 16'd1);
    send_word(3'd0, 3'd0, 1'b0);
    send_word(3'd3, 3'd3, 1'b0);
    send_word(3'd0, 3'd7, 1'b0);   // out of range, still counted
    send_word(3'd7, 3'd0, 1'b0);
    send_word(3'd2, 3'd1, 1'b1);
    send_word(3'd1, 3'd2, 1'b1);   // single-particle tick
    wait_idle();
  endtask

  // Regime count zero, above max, and one.
  task automatic test_regime_count_edges();
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'd0);
    send_word(3'd0, 3'd0, 1'b1);   // tick close with no entries and no emission
    wait_idle();
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'd15);
    send_word(3'd7, 3'd6, 1'b0);
    send_word(3'd6, 3'd7, 1'b1);
    wait_idle();
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'd1);
    send_word(3'd0, 3'd0, 1'b1);
    wait_idle();
  endtask

  // Counts outside a shrunk block are held, then reappear.
  task automatic test_inactive_entries();
    cfg_all(1'b1, 4'd8, 16'd40000, 16'd512, 16'd100, 16'd1);
    send_tick(6, 7);
    wait_idle();
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'd2);
    send_tick(3, 1);
    wait_idle();
    cfg_write(rte_pkg::REG_REGIME_COUNT, 16'd8);
    send_word(3'd5, 3'd6, 1'b1);
    wait_idle();
  endtask

  // Forget all, priors zero: rows with no counts give zero entries.
  task automatic test_zero_row_total();
    cfg_all(1'b1, 4'd8, 16'd0, 16'd0, 16'd0, 16'd1);
    send_word(3'd0, 3'd0, 1'b1);
    wait_idle();
  endtask

  // Interval raised, lowered to the counter's value, then zero.
  task automatic test_interval_changes();
    cfg_all(1'b1, 4'd3, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
    send_tick(2, 2);
    send_tick(2, 2);
    wait_idle();
    cfg_write(rte_pkg::REG_UPDATE_INTERVAL, 16'd2);
    send_tick(1, 2);
    wait_idle();
    cfg_write(rte_pkg::REG_UPDATE_INTERVAL, 16'd0);
    send_tick(2, 2);
    wait_idle();
  endtask

  // Receiver holds off while ticks keep coming: the input must back up.
  task automatic test_output_backpressure();
    cfg_all(1'b1, 4'd8, 16'd60000, 16'd1000, 16'd50, 16'd1);
    hold_seq++;
    for (int i = 0; i < 24; i++)
      send_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), i % 4 == 3);
    wait_idle();
  endtask

  // Random phases with random settings; last phase runs without idling.
  task automatic test_random_phases();
    int unsigned sel;
    bit [3:0] rc;
    bit [15:0] ui;
    bit [15:0] ff;
    for (int ph = 0; ph < 7; ph++) begin
      sel = $urandom_range(0, 9);
      rc = (sel == 0) ? 4'd0 : (sel == 1) ? 4'($urandom_range(9, 15)) :
           4'($urandom_range(1, 8));
      sel = $urandom_range(0, 9);
      ui = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd65535 : 16'($urandom_range(1, 3));
      sel = $urandom_range(0, 5);
      ff = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd65535 : 16'($urandom);
      cfg_all(ph != 2, rc, ff, 16'($urandom),
              $urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom), ui);
      if (ph == 6) quiet = 1'b1;
      for (int i = 0; i < 42; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(3'($urandom), 3'($urandom), $urandom_range(0, 7) == 0);   // noise
        else
          send_word(3'($urandom_range(0, (rc > 8 || rc == 0) ? 7 : rc - 1)),
                    3'($urandom_range(0, (rc > 8 || rc == 0) ? 7 : rc - 1)),
                    $urandom_range(0, 7) == 0 || i == 41);
      end
      wait_idle();
    end
  endtask

  initial begin
    m_learn = 1'b0;
    m_regimes = 4'd4;
    m_forget = 16'd65208;
    m_prior_diag = 16'd12800;
    m_prior_off = 16'd256;
    m_interval = 16'd100;
    foreach (m_counts[i]) m_counts[i] = '0;
    foreach (pair_tally[i]) pair_tally[i] = '0;
    tick_particles = '0;
    ticks_since_matrix = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_basic_tick();
    test_regime_count_edges();
    test_inactive_entries();
    test_zero_row_total();
    test_interval_changes();
    test_output_backpressure();
    test_random_phases();

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
